@@ hdl/ssc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the sliding convolution sign block
// Beat types of both channels, register indexes, sign codes and sizes.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // Default sizes for the top level parameters
    localparam int KSIZE_DEF     = 5;
    localparam int MAX_WIDTH_DEF = 1024;

    // Pixel and coefficient formats
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 9;
    localparam int PROD_W  = 17;

    // Configuration register file
    localparam int NUM_KROWS   = 7;
    localparam int KROW_W      = 63;
    localparam int IMG_W_W     = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 63;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET = 11'd640;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd7;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    // Sign codes
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } pix_beat_t;

    typedef struct packed {
        logic signed [1:0] sign_result;
        logic              row_end;
    } res_beat_t;

    // Control that travels with one window
    typedef struct packed {
        logic vld;
        logic row_end;
    } ssc_ctl_t;

endpackage

@@ hdl/ssc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front: pixel intake, line buffers and window
// Tracks row and column, ages the line buffers, shifts the window and
// pushes every complete window into the queue with its row-end mark.
// ----------------------------------------------------------------------------
module ssc_front #(
    parameter int KSIZE     = ssc_pkg::KSIZE_DEF,
    parameter int MAX_WIDTH = ssc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pix_valid,
    output logic                                   pix_stall,
    input  ssc_pkg::pix_beat_t                     pix_beat,
    input  logic [ssc_pkg::IMG_W_W-1:0]            image_width,
    input  logic [ssc_pkg::QLEVEL_W-1:0]           q_level,
    output ssc_pkg::ssc_ctl_t                      push_ctl,
    output logic [KSIZE*KSIZE-1:0][ssc_pkg::PIX_W-1:0] push_window
);
    import ssc_pkg::*;

    localparam int LINES = KSIZE - 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(KSIZE);
    localparam int MWW   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((IMG_W_W > MWW) ? IMG_W_W : MWW) + 1;
    localparam int SUM_W = QLEVEL_W + 1;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic           accept;
    logic           last;
    logic           win_ok;
    logic [CMP_W-1:0] iw_ext;
    logic [CMP_W-1:0] eff_width;

    // Stage B: the beat whose line buffer data is being read back
    logic           s1_valid_reg;
    logic [CW-1:0]  s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic           s1_win_ok_reg;
    logic           s1_last_reg;
    logic           byp_reg;

    logic [LINES-1:0][PIX_W-1:0] rd_data;
    logic [LINES-1:0][PIX_W-1:0] byp_data_reg;
    logic [LINES-1:0][PIX_W-1:0] wr_data;
    logic [KSIZE-1:0][PIX_W-1:0] column;

    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_reg, window_next;

    // Hold the beat when queue plus stage B could not take it
    assign pix_stall = ({1'b0, q_level} + SUM_W'(s1_valid_reg)) >= SUM_W'(QUEUE_DEPTH);
    assign accept    = pix_valid && !pix_stall;

    // Clamp the configured width into the legal range
    assign iw_ext = CMP_W'(image_width);
    always_comb
    begin
        if (iw_ext < CMP_W'(KSIZE))
            eff_width = CMP_W'(KSIZE);
        else if (iw_ext > CMP_W'(MAX_WIDTH))
            eff_width = CMP_W'(MAX_WIDTH);
        else
            eff_width = iw_ext;
    end

    // Classify the incoming beat
    assign col_cur = pix_beat.frame_start ? '0 : col_reg;
    assign row_cur = pix_beat.frame_start ? '0 : row_reg;
    assign last    = (CMP_W'(col_cur) + CMP_W'(1)) >= eff_width;
    assign win_ok  = (row_cur == RW'(KSIZE - 1)) && (CMP_W'(col_cur) >= CMP_W'(KSIZE - 1));

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = (row_cur == RW'(KSIZE - 1)) ? row_cur : row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            byp_reg      <= accept && s1_valid_reg && (col_cur == s1_col_reg);
        end
    end

    // Capture the beat payload for stage B
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= col_cur;
            s1_pix_reg    <= pix_beat.pixel_value;
            s1_win_ok_reg <= win_ok;
            s1_last_reg   <= last;
        end
        if (s1_valid_reg)
            byp_data_reg <= wr_data;
    end

    // Assemble the column: forward the write in flight at the same column
    always_comb
    begin
        for (int r = 0; r < LINES; r++)
            column[r] = byp_reg ? byp_data_reg[r] : rd_data[r];
        column[KSIZE-1] = s1_pix_reg;
        for (int r = 0; r < LINES; r++)
            wr_data[r] = column[r+1];
    end

    // Line buffers: read at intake, write the aged column in stage B
    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (s1_valid_reg)
                mem[s1_col_reg] <= wr_data[g];
            if (accept)
                rd_reg <= mem[col_cur];
        end

        assign rd_data[g] = rd_reg;
    end

    // Shift the window left and insert the new column
    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
                window_next[r][c] = window_reg[r][c+1];
            window_next[r][KSIZE-1] = column[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            window_reg <= window_next;
    end

    // Push only windows that lie fully inside the image
    assign push_ctl.vld     = s1_valid_reg && s1_win_ok_reg;
    assign push_ctl.row_end = s1_last_reg;
    assign push_window      = window_next;

endmodule

@@ hdl/ssc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue: short window queue between front and back
// Small register queue; reports its fill level to the front for flow control.
// ----------------------------------------------------------------------------
module ssc_queue #(
    parameter int KSIZE = ssc_pkg::KSIZE_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  ssc_pkg::ssc_ctl_t                           push_ctl,
    input  logic [KSIZE*KSIZE-1:0][ssc_pkg::PIX_W-1:0]  push_window,
    input  logic                                        pop,
    output ssc_pkg::ssc_ctl_t                           head_ctl,
    output logic [KSIZE*KSIZE-1:0][ssc_pkg::PIX_W-1:0]  head_window,
    output logic [ssc_pkg::QLEVEL_W-1:0]                level
);
    import ssc_pkg::*;

    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] win_q [QUEUE_DEPTH];
    logic                              end_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QLEVEL_W-1:0] level_reg, level_next;
    logic                do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_comb
    begin
        level_next = level_reg;
        if (push_ctl.vld && !do_pop)
            level_next = level_reg + QLEVEL_W'(1);
        else if (!push_ctl.vld && do_pop)
            level_next = level_reg - QLEVEL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push_ctl.vld)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            level_reg <= level_next;
        end
    end

    // Store the pushed window
    always_ff @(posedge clk)
    begin
        if (push_ctl.vld)
        begin
            win_q[wr_ptr_reg] <= push_window;
            end_q[wr_ptr_reg] <= push_ctl.row_end;
        end
    end

    assign head_ctl.vld     = (level_reg != '0);
    assign head_ctl.row_end = end_q[rd_ptr_reg];
    assign head_window      = win_q[rd_ptr_reg];
    assign level            = level_reg;

endmodule

@@ hdl/ssc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back: multiply-accumulate and sign
// Parallel products, registered row sums, then the total and its sign in
// the output register. Each stage advances when the next one has room.
// ----------------------------------------------------------------------------
module ssc_back #(
    parameter int KSIZE = ssc_pkg::KSIZE_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  ssc_pkg::ssc_ctl_t                                      head_ctl,
    input  logic [KSIZE*KSIZE-1:0][ssc_pkg::PIX_W-1:0]             head_window,
    output logic                                                   pop,
    input  logic [ssc_pkg::NUM_KROWS-1:0][ssc_pkg::KROW_W-1:0]     kernel_rows,
    output logic                                                   res_valid,
    input  logic                                                   res_stall,
    output ssc_pkg::res_beat_t                                     res_beat
);
    import ssc_pkg::*;

    localparam int ROW_W = PROD_W + $clog2(KSIZE);
    localparam int SUM_W = ROW_W + $clog2(KSIZE);

    logic signed [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] prod_next, p1_prod_reg;
    logic signed [KSIZE-1:0][ROW_W-1:0]             row_next, p2_row_reg;
    logic signed [SUM_W-1:0]                        total;
    logic signed [1:0]                              sign_next;
    logic p1_valid_reg, p2_valid_reg, res_valid_reg;
    logic p1_end_reg, p2_end_reg;
    res_beat_t res_beat_reg;
    logic out_adv, p2_adv, p1_adv;

    // Advance when the downstream stage is empty or moving
    assign out_adv = !res_valid_reg || !res_stall;
    assign p2_adv  = !p2_valid_reg || out_adv;
    assign p1_adv  = !p1_valid_reg || p2_adv;
    assign pop     = head_ctl.vld && p1_adv;

    // Coefficient times pixel for every window position
    always_comb
    begin
        logic signed [COEF_W-1:0] coef;
        logic signed [PIX_W:0]    pix;
        logic signed [COEF_W+PIX_W:0] full;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE; c++)
            begin
                coef = $signed(kernel_rows[r][COEF_W*c +: COEF_W]);
                pix  = $signed({1'b0, head_window[r*KSIZE + c]});
                full = coef * pix;
                prod_next[r][c] = full[PROD_W-1:0];
            end
        end
    end

    // Sum each kernel row
    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            row_next[r] = '0;
            for (int c = 0; c < KSIZE; c++)
                row_next[r] = row_next[r] + ROW_W'($signed(p1_prod_reg[r][c]));
        end
    end

    // Total of the row sums and its sign
    always_comb
    begin
        total = '0;
        for (int r = 0; r < KSIZE; r++)
            total = total + SUM_W'($signed(p2_row_reg[r]));
        if (total[SUM_W-1])
            sign_next = SIGN_NEG;
        else if (total == '0)
            sign_next = SIGN_ZERO;
        else
            sign_next = SIGN_POS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_adv)
                p1_valid_reg <= head_ctl.vld;
            if (p2_adv)
                p2_valid_reg <= p1_valid_reg;
            if (out_adv)
                res_valid_reg <= p2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (p1_adv && head_ctl.vld)
        begin
            p1_prod_reg <= prod_next;
            p1_end_reg  <= head_ctl.row_end;
        end
        if (p2_adv && p1_valid_reg)
        begin
            p2_row_reg <= row_next;
            p2_end_reg <= p1_end_reg;
        end
        if (out_adv && p2_valid_reg)
        begin
            res_beat_reg.sign_result <= sign_next;
            res_beat_reg.row_end     <= p2_end_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

endmodule

@@ hdl/sign_of_sliding_convolution.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_of_sliding_convolution: sign of a sliding 2-D convolution
// Raster pixels in, sign of each full-window kernel sum out.
//
//   channel   dir  handshake                 beat
//   pixel     in   pix_valid / pix_stall     pix_beat (pixel_value, frame_start)
//   result    out  res_valid / res_stall     res_beat (sign_result, row_end)
//   config    in   cfg_write                 cfg_index, cfg_data
//
// One pixel per cycle is taken while pix_stall is low. The line buffers are
// one read and one write per line per cycle, which sets the one pixel per
// clock rate. A four-entry window queue lets the front keep taking pixels
// while the result side stalls. Reset clears positions and pipeline valids;
// line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module sign_of_sliding_convolution #(
    parameter int KSIZE     = ssc_pkg::KSIZE_DEF,
    parameter int MAX_WIDTH = ssc_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  ssc_pkg::pix_beat_t                pix_beat,
    output logic                              res_valid,
    input  logic                              res_stall,
    output ssc_pkg::res_beat_t                res_beat,
    input  logic                              cfg_write,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ssc_pkg::*;

    logic [NUM_KROWS-1:0][KROW_W-1:0] kernel_rows_reg;
    logic [IMG_W_W-1:0]               image_width_reg;

    ssc_ctl_t                          push_ctl, head_ctl;
    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] push_window, head_window;
    logic [QLEVEL_W-1:0]               q_level;
    logic                              q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_rows_reg <= '0;
            image_width_reg <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                image_width_reg <= cfg_data[IMG_W_W-1:0];
            else
                kernel_rows_reg[cfg_index] <= cfg_data[KROW_W-1:0];
        end
    end

    ssc_front #(
        .KSIZE     (KSIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_beat    (pix_beat),
        .image_width (image_width_reg),
        .q_level     (q_level),
        .push_ctl    (push_ctl),
        .push_window (push_window)
    );

    ssc_queue #(
        .KSIZE (KSIZE)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_ctl    (push_ctl),
        .push_window (push_window),
        .pop         (q_pop),
        .head_ctl    (head_ctl),
        .head_window (head_window),
        .level       (q_level)
    );

    ssc_back #(
        .KSIZE (KSIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_ctl    (head_ctl),
        .head_window (head_window),
        .pop         (q_pop),
        .kernel_rows (kernel_rows_reg),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_beat    (res_beat)
    );

    // Queue never overflows: a push into a full queue must pop the same cycle
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_ctl.vld |-> (q_level < QLEVEL_W'(QUEUE_DEPTH)) || q_pop)
        else $error("window pushed into full queue");

    // A pixel is only taken with room left for it in the queue
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |-> (q_level < QLEVEL_W'(QUEUE_DEPTH)))
        else $error("pixel taken without queue room");

    // Result sign is always a legal code
    a_sign_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_beat.sign_result == SIGN_NEG) ||
                      (res_beat.sign_result == SIGN_ZERO) ||
                      (res_beat.sign_result == SIGN_POS))
        else $error("illegal sign code");

    // Pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> head_ctl.vld && (q_level != '0))
        else $error("pop from empty queue");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sign_of_sliding_convolution
// Streams raster frames of pixels through the block under random sender gaps
// and result stalls. Each accepted pixel beat runs through a local window
// predictor, and every result beat is checked against the oldest predicted
// sign. Kernel rows and image width are reloaded between drained phases.
// ----------------------------------------------------------------------------
module tb;

    import ssc_pkg::*;

    localparam int KS    = KSIZE_DEF;
    localparam int MAXW  = MAX_WIDTH_DEF;
    localparam int LINES = KS - 1;

    localparam logic [CFG_IDX_W-1:0] REG_KROW_BASE = 3'd0;
    localparam logic [COEF_W-1:0]    COEF_MAX      = 9'h0FF;
    localparam logic [COEF_W-1:0]    COEF_MIN      = 9'h100;

    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int NUM_PHASES    = 10;
    localparam int WIDE_PHASE    = 4;
    localparam int PHASE_BEATS   = 95;
    localparam int WIDE_BEATS    = 60;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               pix_valid = 1'b0;
    logic               pix_stall;
    pix_beat_t          pix_beat  = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_beat_t          res_beat;
    logic               cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Register mirror and next setting to load
    logic [KROW_W-1:0]     kern_rows [NUM_KROWS];
    logic [IMG_W_W-1:0]    img_width = WIDTH_RESET;
    logic [KROW_W-1:0]     plan_rows [NUM_KROWS];
    logic [CFG_DATA_W-1:0] plan_width;

    // Window predictor state
    bit [PIX_W-1:0] line_mem [LINES][MAXW];
    bit [PIX_W-1:0] win [KS][KS];
    int             pos_col;
    int             pos_row;

    // Position tracking for stimulus, kept ahead of the driver
    int             gen_col;
    int             gen_row;
    int             col_fill [MAXW];
    bit             col_ready [MAXW];

    pix_beat_t      pix_todo [$];
    res_beat_t      pending_signs [$];
    int             idle_mode;
    int             fail_count;
    int             quiet_cycles;

    wire pix_take = pix_valid && !pix_stall;
    wire res_take = res_valid && !res_stall;

    sign_of_sliding_convolution #(
        .KSIZE     (KS),
        .MAX_WIDTH (MAXW)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_beat  (pix_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp the width register to the range the block supports
    function automatic int eff_width();
        if (img_width < KS)
            return KS;
        if (img_width > MAXW)
            return MAXW;
        return img_width;
    endfunction

    // Shift one pixel into the line buffers and window; queue its sign if the
    // window lies fully inside the image
    function automatic void conv_sign_step(input pix_beat_t b);
        int        wid;
        int        col;
        int        r;
        int        c;
        int        acc;
        int        cv;
        int        pv;
        bit        is_last;
        bit [PIX_W-1:0] vcol [KS];
        logic signed [COEF_W-1:0] cf;
        res_beat_t want;
        wid = eff_width();
        if (b.frame_start)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        col = (pos_col >= MAXW) ? MAXW - 1 : pos_col;
        for (r = 0; r < LINES; r++)
            vcol[r] = line_mem[r][col];
        vcol[KS-1] = b.pixel_value;
        for (r = 0; r + 1 < LINES; r++)
            line_mem[r][col] = line_mem[r+1][col];
        line_mem[LINES-1][col] = b.pixel_value;
        for (r = 0; r < KS; r++)
        begin
            for (c = 0; c + 1 < KS; c++)
                win[r][c] = win[r][c+1];
            win[r][KS-1] = vcol[r];
        end
        is_last = (pos_col + 1 >= wid);
        if (pos_row >= KS - 1 && pos_col >= KS - 1)
        begin
            acc = 0;
            for (r = 0; r < KS; r++)
                for (c = 0; c < KS; c++)
                begin
                    cf  = kern_rows[r][COEF_W*c +: COEF_W];
                    cv  = cf;
                    pv  = win[r][c];
                    acc += cv * pv;
                end
            want.sign_result = (acc < 0) ? SIGN_NEG : ((acc > 0) ? SIGN_POS : SIGN_ZERO);
            want.row_end     = is_last;
            pending_signs = {pending_signs, want};
        end
        if (is_last)
        begin
            pos_col = 0;
            if (pos_row < KS - 1)
                pos_row++;
        end
        else
            pos_col++;
    endfunction

    // A full window must not read a line buffer entry that was never written
    function automatic bit window_ready(input bit sof);
        int col;
        int row;
        int k;
        col = sof ? 0 : gen_col;
        row = sof ? 0 : gen_row;
        if (row < KS - 1 || col < KS - 1)
            return 1'b1;
        if (col_fill[col] < LINES)
            return 1'b0;
        for (k = 1; k < KS; k++)
            if (!col_ready[col-k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Queue one pixel; restart the frame where the window would be unsafe
    function automatic void push_pixel(input logic [PIX_W-1:0] pv, input bit sof);
        pix_beat_t b;
        if (!window_ready(sof))
            sof = 1'b1;
        if (sof)
        begin
            gen_col = 0;
            gen_row = 0;
        end
        col_ready[gen_col] = (col_fill[gen_col] >= LINES);
        if (col_fill[gen_col] < LINES)
            col_fill[gen_col]++;
        if (gen_col + 1 >= eff_width())
        begin
            gen_col = 0;
            if (gen_row < KS - 1)
                gen_row++;
        end
        else
            gen_col++;
        b.pixel_value = pv;
        b.frame_start = sof;
        pix_todo = {pix_todo, b};
    endfunction

    function automatic void set_coef(input int r, input int c, input logic [COEF_W-1:0] v);
        plan_rows[r][COEF_W*c +: COEF_W] = v;
    endfunction

    function automatic bit gap_roll();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 30;
            1:       return $urandom_range(0, 99) < 45;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit stall_roll();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 45;
            1:       return $urandom_range(0, 99) < 30;
            default: return 1'b0;
        endcase
    endfunction

    // Write every kernel row and the width; the block is idle here
    task automatic load_config();
        int r;
        for (r = 0; r < NUM_KROWS; r++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= REG_KROW_BASE + CFG_IDX_W'(r);
            cfg_data  <= plan_rows[r];
            kern_rows[r] = plan_rows[r];
        end
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= plan_width;
        img_width = plan_width[IMG_W_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every queued pixel is taken and every sign has come back
    task automatic wait_idle();
        while (pix_todo.size() != 0 || pix_valid || pending_signs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: hold a stalled beat, otherwise load the next or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix_beat  <= '0;
        end
        else
        begin
            if (pix_take)
                conv_sign_step(pix_beat);
            if (!pix_valid || !pix_stall)
            begin
                if (pix_todo.size() != 0 && !gap_roll())
                begin
                    pix_valid <= 1'b1;
                    pix_beat  <= pix_todo.pop_front();
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each beat with the oldest predicted sign
    always @(posedge clk or negedge rst_n)
    begin : result_check
        res_beat_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_take)
            begin
                if (pending_signs.size() == 0)
                begin
                    $error("unexpected result beat: sign_result %0d row_end %0d",
                           res_beat.sign_result, res_beat.row_end);
                    fail_count++;
                end
                else
                begin
                    want = pending_signs.pop_front();
                    if (res_beat.sign_result !== want.sign_result)
                    begin
                        $error("sign_result: expected %0d, got %0d",
                               want.sign_result, res_beat.sign_result);
                        fail_count++;
                    end
                    if (res_beat.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0d, got %0d",
                               want.row_end, res_beat.row_end);
                        fail_count++;
                    end
                end
            end
            res_stall <= stall_roll();
        end
    end

    // Watchdog on cycles where neither channel moves a beat
    always @(posedge clk)
    begin
        if (pix_take || res_take)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int ph;
        int n;
        int r;
        int p;
        int v;
        int budget;
        int frame_left;
        int pix_mode;
        int style;
        bit sof;
        logic [PIX_W-1:0] flat_val;
        logic [PIX_W-1:0] pv;

        idle_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // All coefficients at the positive extreme, width below kernel size
        for (r = 0; r < NUM_KROWS; r++)
            plan_rows[r] = {NUM_KROWS{COEF_MAX}};
        plan_width = '0;
        load_config();
        for (n = 0; n < KS * KS; n++)
            push_pixel(8'hFF, n == 0);
        wait_idle();

        // Negative extreme, stream continues without a frame start
        for (r = 0; r < NUM_KROWS; r++)
            plan_rows[r] = {NUM_KROWS{COEF_MIN}};
        load_config();
        for (n = 0; n < KS; n++)
            push_pixel(8'hFF, 1'b0);
        wait_idle();

        // Only the newest pixel weighted, dark pixels give a zero sum
        for (r = 0; r < NUM_KROWS; r++)
            plan_rows[r] = '0;
        set_coef(KS - 1, KS - 1, COEF_MAX);
        load_config();
        for (n = 0; n < KS; n++)
            push_pixel(8'h00, 1'b0);
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_mode = (ph < 3) ? 0 : ((ph < 6) ? 1 : 2);

            // Pick a kernel: random bits, zero-sum pairs, or a single tap
            style = $urandom_range(0, 2);
            for (r = 0; r < NUM_KROWS; r++)
                plan_rows[r] = (style == 0 || r >= KS) ? KROW_W'({$urandom, $urandom}) : '0;
            if (style == 1)
            begin
                for (p = 0; p < (KS * KS) / 2; p++)
                begin
                    v = $urandom_range(0, 510) - 255;
                    set_coef(p / KS, p % KS, COEF_W'(v));
                    set_coef((KS * KS - 1 - p) / KS, (KS * KS - 1 - p) % KS, COEF_W'(-v));
                end
            end
            else if (style == 2)
            begin
                case ($urandom_range(0, 2))
                    0:       v = 255;
                    1:       v = -256;
                    default: v = $urandom_range(0, 511);
                endcase
                set_coef($urandom_range(0, KS - 1), $urandom_range(0, KS - 1), COEF_W'(v));
            end

            // Width: mostly small, sometimes below kernel size, once above max
            plan_width = CFG_DATA_W'({$urandom, $urandom});
            if (ph == WIDE_PHASE)
                plan_width[IMG_W_W-1:0] = '1;
            else if (ph == WIDE_PHASE + 1)
                plan_width[IMG_W_W-1:0] = IMG_W_W'(8);
            else if ($urandom_range(0, 9) == 0)
                plan_width[IMG_W_W-1:0] = IMG_W_W'($urandom_range(0, KS - 1));
            else
                plan_width[IMG_W_W-1:0] = IMG_W_W'($urandom_range(KS, 14));
            load_config();

            // Either restart the frame or carry on under the new width
            frame_left = 0;
            if (ph == WIDE_PHASE + 1 || (ph != WIDE_PHASE && $urandom_range(0, 3) == 0))
            begin
                frame_left = eff_width() * (KS + $urandom_range(0, 3));
                pix_mode   = 0;
            end
            budget = (ph == WIDE_PHASE) ? WIDE_BEATS : PHASE_BEATS;

            for (n = 0; n < budget; n++)
            begin
                sof = 1'b0;
                if (frame_left == 0)
                begin
                    frame_left = eff_width() * (KS + $urandom_range(0, 3))
                                 + $urandom_range(0, 3);
                    sof        = 1'b1;
                    pix_mode   = $urandom_range(0, 2);
                    flat_val   = $urandom_range(0, 255);
                end
                // Stray frame start breaks the current frame
                if ($urandom_range(0, 99) < 3)
                    sof = 1'b1;
                case (pix_mode)
                    0:       pv = $urandom_range(0, 255);
                    1:       pv = flat_val;
                    default: pv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                if ($urandom_range(0, 99) < 3)
                    pv = $urandom_range(0, 255);
                push_pixel(pv, sof);
                frame_left--;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ssc_pkg.sv
hdl/ssc_front.sv
hdl/ssc_queue.sv
hdl/ssc_back.sv
hdl/sign_of_sliding_convolution.sv
sim/tb.sv
